/* hdl/dsh_pkg.sv */
package dsh_pkg;

   // Grid geometry
   localparam int MAX_DETAIL  = 8;
   localparam int HEIGHT_BITS = 24;
   localparam int CW          = MAX_DETAIL + 1;                 // coordinate bits
   localparam int GRID_DIM    = (1 << MAX_DETAIL) + 1;
   localparam int STORE_DEPTH = GRID_DIM * GRID_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LG_W        = 4;                              // detail / log2 step bits

   // Offset arithmetic: (rv - 32768) * roughness * step in Q16.8 needs a shift of 15+12-8
   localparam int PROD_W      = 33;
   localparam int OFF_SHIFT   = 19;
   localparam int OFF_W       = MAX_DETAIL + 14;
   localparam int ACC_W       = ((HEIGHT_BITS > OFF_W) ? HEIGHT_BITS : OFF_W) + 4;

   // Register map
   localparam int  CSR_ADDR_W   = 3;
   localparam logic REG_DETAIL  = 1'b0;
   localparam logic REG_ROUGH   = 1'b1;
   localparam logic [3:0]  DETAIL_RESET = 4'd5;
   localparam logic [15:0] ROUGH_RESET  = 16'd2048;

   // Where one neighbor read takes its value from
   typedef enum logic [1:0] {
      SRC_MEM,
      SRC_ZERO,
      SRC_CORNER,
      SRC_FWD
   } src_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      src_type           src;
   } rd_req_type;

   typedef struct packed {
      logic                          en;
      logic [ADDR_W-1:0]             addr;
      logic signed [HEIGHT_BITS-1:0] data;
   } wr_req_type;

   typedef logic signed [CW+1:0] scoord_type;

   typedef struct packed {
      scoord_type c;
      scoord_type r;
   } nbr_type;

   // Neighbor k of a point: diagonals in the square pass, axis points in the diamond pass
   function automatic nbr_type nbr_point(input logic [CW-1:0] col,
                                         input logic [CW-1:0] row,
                                         input logic [CW-1:0] half,
                                         input logic          diamond,
                                         input logic [1:0]    k);
      nbr_type    p;
      scoord_type c;
      scoord_type r;
      scoord_type h;
      c = {2'b00, col};
      r = {2'b00, row};
      h = {2'b00, half};
      p.c = c;
      p.r = r;
      if (!diamond) begin
         case (k)
            2'd0: begin p.c = c - h; p.r = r - h; end
            2'd1: begin p.c = c + h; p.r = r - h; end
            2'd2: begin p.c = c + h; p.r = r + h; end
            default: begin p.c = c - h; p.r = r + h; end
         endcase
      end else begin
         case (k)
            2'd0: p.r = r - h;
            2'd1: p.c = c + h;
            2'd2: p.r = r + h;
            default: p.c = c - h;
         endcase
      end
      return p;
   endfunction

   // Clamp to the signed height range
   function automatic logic signed [HEIGHT_BITS-1:0] sat_height(
         input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      logic signed [ACC_W-1:0] s;
      hi = ACC_W'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
      lo = ~hi;
      s  = v;
      if (v > hi) s = hi;
      if (v < lo) s = lo;
      return s[HEIGHT_BITS-1:0];
   endfunction

endpackage

/* hdl/dsh_height_store.sv */
module dsh_height_store (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dsh_pkg::rd_req_type                    rd_req,
   input  dsh_pkg::wr_req_type                    wr_req,
   input  logic signed [dsh_pkg::HEIGHT_BITS-1:0] corner_height,
   output logic signed [dsh_pkg::HEIGHT_BITS-1:0] rd_value
);

   logic signed [dsh_pkg::HEIGHT_BITS-1:0] mem [dsh_pkg::STORE_DEPTH];
   logic signed [dsh_pkg::HEIGHT_BITS-1:0] mem_q_ff;
   logic signed [dsh_pkg::HEIGHT_BITS-1:0] fwd_ff;
   dsh_pkg::src_type                       src_ff;

   // Height memory, one write and one read per cycle, registered read
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
      if (rd_req.en) begin
         mem_q_ff <= mem[rd_req.addr];
         fwd_ff   <= wr_req.data;
      end
   end

   // Source of the pending read; a write to the same entry at the same edge is forwarded
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= dsh_pkg::SRC_ZERO;
      end else if (rd_req.en) begin
         if (rd_req.src == dsh_pkg::SRC_MEM && wr_req.en && wr_req.addr == rd_req.addr) begin
            src_ff <= dsh_pkg::SRC_FWD;
         end else begin
            src_ff <= rd_req.src;
         end
      end
   end

   always_comb begin
      case (src_ff)
         dsh_pkg::SRC_MEM:    rd_value = mem_q_ff;
         dsh_pkg::SRC_CORNER: rd_value = corner_height;
         dsh_pkg::SRC_FWD:    rd_value = fwd_ff;
         default:             rd_value = '0;
      endcase
   end

endmodule

/* hdl/diamond_square_heightmap.sv */
// Diamond-square height map generator.
// req channel: one item per random word (req_tdata[15:0]). rsp channel: one item per
// computed point, column, row and Q16.8 height in rsp_tdata, rsp_tlast on the final
// point of the map. After that the next item starts a fresh map.
// csr port: detail_level at 0x0, roughness at 0x4. Write only while idle; a detail
// write restarts the map from its corners.
// Timing: an accepted item issues its four neighbor reads one after another, starting
// in the accepting cycle, on the single read port of the height memory; the point is
// written and its result registered once the output register is free, raising rsp_tvalid.
// A new item is taken in the cycle the previous one finishes, not before; the four
// reads per point all go through one memory read port.
// Reset: the map restarts at detail 5, roughness 2048; corners are held as a constant
// outside the memory, so no clearing pass is needed and req_tready is high at once.
// Stall: the finished result waits in the output register; the next item's reads run
// meanwhile, and it completes once the output register is free.
module diamond_square_heightmap (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: random_value[15:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // rsp_tdata: column[8:0], row[17:9], height[41:18], zero pad[47:42]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [dsh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW  = dsh_pkg::CW;
   localparam int HB  = dsh_pkg::HEIGHT_BITS;
   localparam int AW  = dsh_pkg::ACC_W;
   localparam logic [2:0] STAGE_FINAL = 3'd4;

   function automatic logic [dsh_pkg::LG_W-1:0] clamp_detail(input logic [3:0] d);
      logic [dsh_pkg::LG_W-1:0] e;
      e = dsh_pkg::LG_W'(d);
      if (d == 4'd0) e = dsh_pkg::LG_W'(1);
      if (32'(d) > dsh_pkg::MAX_DETAIL) e = dsh_pkg::LG_W'(dsh_pkg::MAX_DETAIL);
      return e;
   endfunction

   // Configuration registers
   logic [3:0]  detail_ff;
   logic [15:0] rough_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == dsh_pkg::REG_ROUGH) ? {16'b0, rough_ff}
                                                           : {28'b0, detail_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         detail_ff <= dsh_pkg::DETAIL_RESET;
         rough_ff  <= dsh_pkg::ROUGH_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == dsh_pkg::REG_DETAIL) begin
            detail_ff <= csr_pwdata[3:0];
         end else begin
            rough_ff <= csr_pwdata[15:0];
         end
      end
   end

   // Grid span and corner height
   logic [dsh_pkg::LG_W-1:0] eff_lg;
   logic [dsh_pkg::LG_W-1:0] wr_lg;
   logic [CW-1:0]            span;
   dsh_pkg::scoord_type      span_s;
   logic signed [HB-1:0]     corner_height;

   assign eff_lg        = clamp_detail(detail_ff);
   assign wr_lg         = clamp_detail(csr_pwdata[3:0]);
   assign span          = CW'(1) << eff_lg;
   assign span_s        = {2'b00, span};
   assign corner_height = dsh_pkg::sat_height(AW'(span) <<< 7);

   // Traversal cursor
   logic [dsh_pkg::LG_W-1:0] lg_ff, lg_in;
   logic [CW-1:0]            col_ff, col_in;
   logic [CW-1:0]            row_ff, row_in;
   logic                     diamond_ff, diamond_in;
   logic                     last_now;
   logic [CW-1:0]            step, half;
   logic [CW:0]              col_sum, row_sum;
   logic [CW-1:0]            row_next;

   assign step = CW'(1) << lg_ff;
   assign half = step >> 1;

   always_comb begin
      lg_in      = lg_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      diamond_in = diamond_ff;
      last_now   = 1'b0;
      col_sum    = {1'b0, col_ff} + {1'b0, step};
      row_sum    = '0;
      row_next   = '0;
      if (!diamond_ff) begin
         row_sum = {1'b0, row_ff} + {1'b0, step};
         if (col_sum >= {1'b0, span}) begin
            col_in = half;
            if (row_sum >= {1'b0, span}) begin
               diamond_in = 1'b1;
               row_in     = '0;
            end else begin
               row_in = row_sum[CW-1:0];
            end
         end else begin
            col_in = col_sum[CW-1:0];
         end
      end else begin
         row_sum  = {1'b0, row_ff} + {1'b0, half};
         row_next = row_sum[CW-1:0];
         if (col_sum > {1'b0, span}) begin
            if (row_sum > {1'b0, span}) begin
               if (lg_ff <= dsh_pkg::LG_W'(1)) begin
                  // final point: start a fresh map
                  last_now   = 1'b1;
                  lg_in      = eff_lg;
                  col_in     = span >> 1;
                  row_in     = span >> 1;
                  diamond_in = 1'b0;
               end else begin
                  lg_in      = lg_ff - dsh_pkg::LG_W'(1);
                  diamond_in = 1'b0;
                  col_in     = half >> 1;
                  row_in     = half >> 1;
               end
            end else begin
               row_in = row_next;
               col_in = (row_next + half) & (step - CW'(1));
            end
         end else begin
            col_in = col_sum[CW-1:0];
         end
      end
   end

   // Item sequencer
   logic       busy_ff;
   logic [2:0] cnt_ff;
   logic       slot_free;
   logic       finish;
   logic       accept;

   assign slot_free  = !rsp_tvalid | rsp_tready;
   assign req_tready = !busy_ff | (cnt_ff == STAGE_FINAL && slot_free);
   assign accept     = req_tvalid & req_tready;
   assign finish     = busy_ff & (cnt_ff == STAGE_FINAL) & slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cnt_ff     <= '0;
         lg_ff      <= clamp_detail(dsh_pkg::DETAIL_RESET);
         col_ff     <= CW'(1) << (clamp_detail(dsh_pkg::DETAIL_RESET) - dsh_pkg::LG_W'(1));
         row_ff     <= CW'(1) << (clamp_detail(dsh_pkg::DETAIL_RESET) - dsh_pkg::LG_W'(1));
         diamond_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end else if (busy_ff && cnt_ff != STAGE_FINAL) begin
            cnt_ff <= cnt_ff + 3'd1;
         end
         if (csr_wr && csr_paddr[2] == dsh_pkg::REG_DETAIL) begin
            lg_ff      <= wr_lg;
            col_ff     <= (CW'(1) << wr_lg) >> 1;
            row_ff     <= (CW'(1) << wr_lg) >> 1;
            diamond_ff <= 1'b0;
         end else if (accept) begin
            lg_ff      <= lg_in;
            col_ff     <= col_in;
            row_ff     <= row_in;
            diamond_ff <= diamond_in;
         end
      end
   end

   // Per-item context, captured at acceptance
   logic [CW-1:0]                 item_col_ff, item_row_ff;
   logic [dsh_pkg::LG_W-1:0]      item_lg_ff;
   logic                          item_diamond_ff;
   logic                          item_last_ff;
   logic [dsh_pkg::ADDR_W-1:0]    item_addr_ff;
   logic signed [dsh_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [15:0]            rv_c;
   logic signed [16:0]            rough_s;
   logic [CW-1:0]                 item_half;

   assign rv_c      = {~req_tdata[15], req_tdata[14:0]};
   assign rough_s   = {1'b0, rough_ff};
   assign prod_in   = dsh_pkg::PROD_W'(rv_c) * dsh_pkg::PROD_W'(rough_s);
   assign item_half = (CW'(1) << item_lg_ff) >> 1;

   always_ff @(posedge clock) begin
      if (accept) begin
         item_col_ff     <= col_ff;
         item_row_ff     <= row_ff;
         item_lg_ff      <= lg_ff;
         item_diamond_ff <= diamond_ff;
         item_last_ff    <= last_now;
         item_addr_ff    <= dsh_pkg::ADDR_W'(row_ff) * dsh_pkg::ADDR_W'(dsh_pkg::GRID_DIM)
                            + dsh_pkg::ADDR_W'(col_ff);
         prod_ff         <= prod_in;
      end
   end

   // Neighbor read request
   dsh_pkg::nbr_type    nbr;
   dsh_pkg::rd_req_type rd_req;
   dsh_pkg::wr_req_type wr_req;
   logic                nbr_inside, nbr_corner;

   always_comb begin
      if (accept) begin
         nbr = dsh_pkg::nbr_point(col_ff, row_ff, half, diamond_ff, 2'd0);
      end else begin
         nbr = dsh_pkg::nbr_point(item_col_ff, item_row_ff, item_half, item_diamond_ff,
                                  cnt_ff[1:0]);
      end
      nbr_inside = !nbr.c[CW+1] && !nbr.r[CW+1] && (nbr.c <= span_s) && (nbr.r <= span_s);
      nbr_corner = (nbr.c == '0 || nbr.c == span_s) && (nbr.r == '0 || nbr.r == span_s);
      rd_req.en   = accept | (busy_ff & (cnt_ff != STAGE_FINAL));
      rd_req.addr = dsh_pkg::ADDR_W'(nbr.r[CW-1:0]) * dsh_pkg::ADDR_W'(dsh_pkg::GRID_DIM)
                    + dsh_pkg::ADDR_W'(nbr.c[CW-1:0]);
      if (!nbr_inside) begin
         rd_req.src = dsh_pkg::SRC_ZERO;
      end else if (nbr_corner) begin
         rd_req.src = dsh_pkg::SRC_CORNER;
      end else begin
         rd_req.src = dsh_pkg::SRC_MEM;
      end
   end

   logic signed [HB-1:0] rd_value;

   dsh_height_store u_store (
      .clock         (clock),
      .reset         (reset),
      .rd_req        (rd_req),
      .wr_req        (wr_req),
      .corner_height (corner_height),
      .rd_value      (rd_value)
   );

   // Offset, then sum of neighbors with four times the offset folded in
   logic signed [dsh_pkg::PROD_W:0]  rnd_sum, rnd_shr;
   logic [4:0]                       rnd_pos, rnd_sh;
   logic signed [dsh_pkg::OFF_W-1:0] off_ff;
   logic signed [AW-1:0]             acc_ff, rv_ext, off_x4, total, mean;
   logic signed [HB-1:0]             height;

   assign rnd_pos = 5'(dsh_pkg::OFF_SHIFT - 1) - 5'(item_lg_ff);
   assign rnd_sh  = 5'(dsh_pkg::OFF_SHIFT) - 5'(item_lg_ff);
   assign rnd_sum = {prod_ff[dsh_pkg::PROD_W-1], prod_ff}
                    + ((dsh_pkg::PROD_W+1)'(1) << rnd_pos);
   assign rnd_shr = rnd_sum >>> rnd_sh;
   assign rv_ext  = AW'(rd_value);
   assign off_x4  = AW'(off_ff) <<< 2;
   assign total   = acc_ff + rv_ext;
   assign mean    = total >>> 2;
   assign height  = dsh_pkg::sat_height(mean);

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         case (cnt_ff)
            3'd1: begin
               acc_ff <= rv_ext;
               off_ff <= rnd_shr[dsh_pkg::OFF_W-1:0];
            end
            3'd2: acc_ff <= acc_ff + rv_ext;
            3'd3: acc_ff <= acc_ff + rv_ext + off_x4;
            default: acc_ff <= acc_ff;
         endcase
      end
   end

   // Write back the point
   assign wr_req.en   = finish;
   assign wr_req.addr = item_addr_ff;
   assign wr_req.data = height;

   // Output register
   logic        rsp_valid_ff;
   logic [8:0]  out_col_ff, out_row_ff;
   logic [23:0] out_height_ff;
   logic        out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         out_col_ff    <= 9'(item_col_ff);
         out_row_ff    <= 9'(item_row_ff);
         out_height_ff <= 24'(height);
         out_last_ff   <= item_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, out_height_ff, out_row_ff, out_col_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
